[hw/rtl/ppid_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppid_pkg
// Shared types and constants of the positional pid controller with integral
// preset: field widths, register indexes, controller states and datapath ops.
// ----------------------------------------------------------------------------
package ppid_pkg;

    // field and datapath widths fixed by the item format
    localparam int CFG_W     = 16;
    localparam int MEAS_W    = 16;
    localparam int PRESET_W  = 24;
    localparam int DRIVE_W   = 16;
    localparam int ERR_W     = 17;
    localparam int DERR_W    = 18;
    localparam int PROD_P_W  = CFG_W + ERR_W;
    localparam int PROD_D_W  = CFG_W + DERR_W;
    localparam int PD_W      = PROD_D_W + 1;
    localparam int KIE_W     = 18;
    localparam int KMAG_W    = 17;
    localparam int MUL_STEPS = KMAG_W;
    localparam int TOTAL_W   = 64;

    // integral range in whole units: [-2^INT_LOW_LOG2, INT_HIGH_WHOLE]
    localparam int INT_LOW_LOG2    = 31;
    localparam int INT_HIGH_WHOLE  = 100;
    // cap on the magnitude of the integral term
    localparam int TERM_LIMIT_LOG2 = 62;

    // output clamp
    localparam int DRIVE_HIGH = -100;
    localparam int DRIVE_LOW  = -20000;

    // register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D = 2'd3;

    // item kinds carried in tuser
    localparam logic ACT_STEP   = 1'b0;
    localparam logic ACT_PRESET = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ERR,
        ST_PMUL,
        ST_DMUL,
        ST_KMUL,
        ST_SAT,
        ST_TOTAL,
        ST_SCALE,
        ST_OUT,
        ST_PLOAD,
        ST_DIV,
        ST_PSTORE
    } ctrl_state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_ERR,
        OP_PMUL,
        OP_DMUL,
        OP_KMUL,
        OP_SAT,
        OP_TOTAL,
        OP_SCALE,
        OP_OUT,
        OP_PLOAD,
        OP_DIV,
        OP_PSTORE
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
    } dp_stat_t;

endpackage

[hw/rtl/ppid_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppid_ctrl
// Sequencer: takes one item at a time and steps the datapath through the
// control-step or preset sequence, counting multiply and divide iterations.
// ----------------------------------------------------------------------------
module ppid_ctrl #(
    parameter int FRACTION_BITS = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic              item_preset,
    output ppid_pkg::dp_cmd_t cmd,
    input  ppid_pkg::dp_stat_t stat
);

    localparam int DIV_STEPS = ppid_pkg::PRESET_W + 2 * FRACTION_BITS;
    localparam int MAX_STEPS = (DIV_STEPS > ppid_pkg::MUL_STEPS) ? DIV_STEPS
                                                                  : ppid_pkg::MUL_STEPS;
    localparam int CNT_W     = $clog2(MAX_STEPS);

    ppid_pkg::ctrl_state_t state_reg, state_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ppid_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ppid_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = (item_preset == ppid_pkg::ACT_PRESET) ? ppid_pkg::ST_PLOAD
                                                                       : ppid_pkg::ST_ERR;
                end
            end
            ppid_pkg::ST_ERR:   state_next = ppid_pkg::ST_PMUL;
            ppid_pkg::ST_PMUL:  state_next = ppid_pkg::ST_DMUL;
            ppid_pkg::ST_DMUL: begin
                state_next = ppid_pkg::ST_KMUL;
                cnt_next   = CNT_W'(ppid_pkg::MUL_STEPS - 1);
            end
            ppid_pkg::ST_KMUL: begin
                if (cnt_reg == '0) begin
                    state_next = ppid_pkg::ST_SAT;
                end else begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            ppid_pkg::ST_SAT:   state_next = ppid_pkg::ST_TOTAL;
            ppid_pkg::ST_TOTAL: state_next = ppid_pkg::ST_SCALE;
            ppid_pkg::ST_SCALE: state_next = ppid_pkg::ST_OUT;
            ppid_pkg::ST_OUT: begin
                if (stat.out_free) begin
                    state_next = ppid_pkg::ST_IDLE;
                end
            end
            ppid_pkg::ST_PLOAD: begin
                state_next = ppid_pkg::ST_DIV;
                cnt_next   = CNT_W'(DIV_STEPS - 1);
            end
            ppid_pkg::ST_DIV: begin
                if (cnt_reg == '0) begin
                    state_next = ppid_pkg::ST_PSTORE;
                end else begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            ppid_pkg::ST_PSTORE: state_next = ppid_pkg::ST_IDLE;
            default:             state_next = ppid_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        s_tready = 1'b0;
        cmd.op   = ppid_pkg::OP_NONE;
        unique case (state_reg)
            ppid_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.op = ppid_pkg::OP_CAPTURE;
                end
            end
            ppid_pkg::ST_ERR:    cmd.op = ppid_pkg::OP_ERR;
            ppid_pkg::ST_PMUL:   cmd.op = ppid_pkg::OP_PMUL;
            ppid_pkg::ST_DMUL:   cmd.op = ppid_pkg::OP_DMUL;
            ppid_pkg::ST_KMUL:   cmd.op = ppid_pkg::OP_KMUL;
            ppid_pkg::ST_SAT:    cmd.op = ppid_pkg::OP_SAT;
            ppid_pkg::ST_TOTAL:  cmd.op = ppid_pkg::OP_TOTAL;
            ppid_pkg::ST_SCALE:  cmd.op = ppid_pkg::OP_SCALE;
            ppid_pkg::ST_OUT: begin
                if (stat.out_free) begin
                    cmd.op = ppid_pkg::OP_OUT;
                end
            end
            ppid_pkg::ST_PLOAD:  cmd.op = ppid_pkg::OP_PLOAD;
            ppid_pkg::ST_DIV:    cmd.op = ppid_pkg::OP_DIV;
            ppid_pkg::ST_PSTORE: cmd.op = ppid_pkg::OP_PSTORE;
            default:             cmd.op = ppid_pkg::OP_NONE;
        endcase
    end

endmodule

[hw/rtl/ppid_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppid_dp
// Datapath: gain and setpoint registers, error and integral state, a
// shift-add multiplier for the integral term, a restoring divider for the
// preset, and the output register with its clamp.
// ----------------------------------------------------------------------------
module ppid_dp #(
    parameter int FRACTION_BITS = 8
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [ppid_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ppid_pkg::CFG_W-1:0]          cfg_wdata,
    input  logic [ppid_pkg::MEAS_W-1:0]         in_measured,
    input  logic [ppid_pkg::PRESET_W-1:0]       in_preset,
    input  ppid_pkg::dp_cmd_t                   cmd,
    output ppid_pkg::dp_stat_t                  stat,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [ppid_pkg::DRIVE_W-1:0]        m_drive
);

    localparam int F      = FRACTION_BITS;
    localparam int IW     = ppid_pkg::INT_LOW_LOG2 + 1 + F;  // integral width
    localparam int PW     = ppid_pkg::KMAG_W + IW;           // product width
    localparam int SW     = (PW > ppid_pkg::TERM_LIMIT_LOG2 + 1) ? PW
                                                              : ppid_pkg::TERM_LIMIT_LOG2 + 1;
    localparam int DW     = ppid_pkg::PRESET_W + 2 * F;      // dividend / quotient
    localparam int QW     = (DW > IW) ? DW : IW;
    localparam int TW     = ppid_pkg::TOTAL_W;
    localparam int SCW    = TW - 2 * F;                      // scaled total
    localparam int KIE_W_L = ppid_pkg::KIE_W;

    localparam logic signed [IW:0]   INT_HIGH_X = (IW + 1)'(ppid_pkg::INT_HIGH_WHOLE) <<< F;
    localparam logic signed [IW:0]   INT_LOW_X  = -((IW + 1)'(1) <<< (ppid_pkg::INT_LOW_LOG2 + F));
    localparam logic signed [IW-1:0] INT_HIGH   = IW'(INT_HIGH_X);
    localparam logic [SW-1:0]        TERM_LIM   = SW'(1) << ppid_pkg::TERM_LIMIT_LOG2;
    localparam logic [QW-1:0]        Q_MAX      = QW'(1) << (ppid_pkg::INT_LOW_LOG2 + F);
    localparam logic [TW-1:0]        RND_BIAS   = (TW'(1) << (2 * F)) - TW'(1);
    localparam logic signed [KIE_W_L-1:0] KI_ONE = KIE_W_L'(1) << F;
    localparam logic signed [SCW-1:0] DRV_MAX = SCW'(ppid_pkg::DRIVE_HIGH);
    localparam logic signed [SCW-1:0] DRV_MIN = SCW'(ppid_pkg::DRIVE_LOW);

    // configuration and state
    logic signed [ppid_pkg::CFG_W-1:0]  target_reg, gain_p_reg, gain_i_reg, gain_d_reg;
    logic                               forced_reg;
    logic signed [ppid_pkg::ERR_W-1:0]  prev_err_reg;
    logic signed [IW-1:0]               integ_reg;

    // captured item
    logic signed [ppid_pkg::MEAS_W-1:0]   meas_reg;
    logic signed [ppid_pkg::PRESET_W-1:0] pv_reg;

    // step pipeline registers
    logic signed [ppid_pkg::ERR_W-1:0]    err_reg;
    logic signed [ppid_pkg::DERR_W-1:0]   derr_reg;
    logic signed [ppid_pkg::PROD_P_W-1:0] prod_p_reg;
    logic signed [ppid_pkg::PROD_D_W-1:0] prod_d_reg;
    logic signed [ppid_pkg::PD_W-1:0]     pd_reg;
    logic [ppid_pkg::KMAG_W-1:0]          kmag_reg;
    logic [IW-1:0]                        mcand_reg;
    logic [PW-1:0]                        acc_reg;
    logic                                 neg_reg;
    logic signed [TW-1:0]                 spm_reg;
    logic signed [TW-1:0]                 total_reg;
    logic signed [SCW-1:0]                scaled_reg;

    // divider
    logic [DW-1:0]                        dvd_reg;
    logic [ppid_pkg::KMAG_W-1:0]          rem_reg;

    // output
    logic                                 m_tvalid_reg;
    logic [ppid_pkg::DRIVE_W-1:0]         m_drive_reg;

    // combinational helpers
    logic signed [ppid_pkg::ERR_W-1:0]    err_c;
    logic signed [ppid_pkg::DERR_W-1:0]   derr_c;
    logic signed [IW:0]                   isum_c;
    logic signed [IW-1:0]                 integ_c;
    logic signed [KIE_W_L-1:0]            ki_eff_c, ki_pre_c;
    logic                                 forced_pre_c;
    logic signed [KIE_W_L-1:0]            ki_neg_c, kp_neg_c;
    logic [ppid_pkg::KMAG_W-1:0]          kmag_c, kmag_pre_c;
    logic signed [IW-1:0]                 integ_neg_c;
    logic signed [ppid_pkg::PROD_P_W-1:0] prod_p_c;
    logic signed [ppid_pkg::PROD_D_W-1:0] prod_d_c;
    logic [PW-1:0]                        acc_step_c;
    logic [SW-1:0]                        acc_x_c, pm_c;
    logic signed [TW-1:0]                 pm_s_c;
    logic signed [TW-1:0]                 biased_c, shifted_c;
    logic signed [SCW-1:0]                drive_c;
    logic signed [ppid_pkg::PRESET_W-1:0] pv_neg_c;
    logic [ppid_pkg::KMAG_W:0]            trial_c;
    logic                                 qbit_c;
    logic [QW-1:0]                        q_c, qsat_c;
    logic signed [QW:0]                   qneg_c;

    always_comb begin
        err_c  = ppid_pkg::ERR_W'(target_reg) - ppid_pkg::ERR_W'(meas_reg);
        derr_c = ppid_pkg::DERR_W'(err_c) - ppid_pkg::DERR_W'(prev_err_reg);
        isum_c = (IW + 1)'(integ_reg) + ((IW + 1)'(err_c) <<< F);
        if (isum_c > INT_HIGH_X) begin
            integ_c = IW'(INT_HIGH_X);
        end else if (isum_c < INT_LOW_X) begin
            integ_c = IW'(INT_LOW_X);
        end else begin
            integ_c = IW'(isum_c);
        end

        // effective ki now, and after a preset has forced a zero ki to one
        ki_eff_c     = forced_reg ? KI_ONE : KIE_W_L'(gain_i_reg);
        ki_neg_c     = -ki_eff_c;
        kmag_c       = ki_eff_c[KIE_W_L-1] ? ppid_pkg::KMAG_W'(ki_neg_c)
                                           : ppid_pkg::KMAG_W'(ki_eff_c);
        forced_pre_c = forced_reg || (gain_i_reg == '0);
        ki_pre_c     = forced_pre_c ? KI_ONE : KIE_W_L'(gain_i_reg);
        kp_neg_c     = -ki_pre_c;
        kmag_pre_c   = ki_pre_c[KIE_W_L-1] ? ppid_pkg::KMAG_W'(kp_neg_c)
                                           : ppid_pkg::KMAG_W'(ki_pre_c);
        integ_neg_c  = -integ_reg;

        prod_p_c = ppid_pkg::PROD_P_W'(gain_p_reg) * ppid_pkg::PROD_P_W'(err_reg);
        prod_d_c = ppid_pkg::PROD_D_W'(gain_d_reg) * ppid_pkg::PROD_D_W'(derr_reg);

        // msb-first shift-add
        acc_step_c = (acc_reg << 1)
                   + (kmag_reg[ppid_pkg::KMAG_W-1] ? PW'(mcand_reg) : '0);

        acc_x_c = SW'(acc_reg);
        pm_c    = (acc_x_c > TERM_LIM) ? TERM_LIM : acc_x_c;
        pm_s_c  = TW'(pm_c[ppid_pkg::TERM_LIMIT_LOG2:0]);

        // truncate toward zero: bias negative totals before the shift
        biased_c  = total_reg + (total_reg[TW-1] ? $signed(RND_BIAS) : '0);
        shifted_c = biased_c >>> (2 * F);

        if (scaled_reg > DRV_MAX) begin
            drive_c = DRV_MAX;
        end else if (scaled_reg < DRV_MIN) begin
            drive_c = DRV_MIN;
        end else begin
            drive_c = scaled_reg;
        end

        pv_neg_c = -pv_reg;
        trial_c  = {rem_reg, dvd_reg[DW-1]};
        qbit_c   = (trial_c >= {1'b0, kmag_reg});

        q_c    = QW'(dvd_reg);
        qsat_c = (q_c > Q_MAX) ? Q_MAX : q_c;
        qneg_c = -$signed({1'b0, qsat_c});
    end

    // configuration, controller state and output handshake
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg   <= '0;
            gain_p_reg   <= '0;
            gain_i_reg   <= '0;
            gain_d_reg   <= '0;
            forced_reg   <= 1'b0;
            prev_err_reg <= '0;
            integ_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (cmd.op)
                ppid_pkg::OP_ERR: begin
                    prev_err_reg <= err_c;
                    integ_reg    <= integ_c;
                end
                ppid_pkg::OP_PLOAD:  forced_reg   <= forced_pre_c;
                ppid_pkg::OP_PSTORE: integ_reg    <= IW'(qneg_c);
                ppid_pkg::OP_OUT:    m_tvalid_reg <= 1'b1;
                default: ;
            endcase
            if (cfg_we) begin
                unique case (cfg_index)
                    ppid_pkg::CFG_TARGET: target_reg <= cfg_wdata;
                    ppid_pkg::CFG_GAIN_P: gain_p_reg <= cfg_wdata;
                    ppid_pkg::CFG_GAIN_I: begin
                        gain_i_reg <= cfg_wdata;
                        forced_reg <= 1'b0;
                    end
                    ppid_pkg::CFG_GAIN_D: gain_d_reg <= cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        case (cmd.op)
            ppid_pkg::OP_CAPTURE: begin
                meas_reg <= in_measured;
                pv_reg   <= in_preset;
            end
            ppid_pkg::OP_ERR: begin
                err_reg  <= err_c;
                derr_reg <= derr_c;
            end
            ppid_pkg::OP_PMUL: prod_p_reg <= prod_p_c;
            ppid_pkg::OP_DMUL: begin
                prod_d_reg <= prod_d_c;
                kmag_reg   <= kmag_c;
                mcand_reg  <= integ_reg[IW-1] ? integ_neg_c : integ_reg;
                acc_reg    <= '0;
                neg_reg    <= ki_eff_c[KIE_W_L-1] ^ integ_reg[IW-1];
            end
            ppid_pkg::OP_KMUL: begin
                acc_reg  <= acc_step_c;
                kmag_reg <= kmag_reg << 1;
            end
            ppid_pkg::OP_SAT: begin
                spm_reg <= neg_reg ? -pm_s_c : pm_s_c;
                pd_reg  <= ppid_pkg::PD_W'(prod_p_reg) + ppid_pkg::PD_W'(prod_d_reg);
            end
            ppid_pkg::OP_TOTAL: total_reg  <= (TW'(pd_reg) <<< F) + spm_reg;
            ppid_pkg::OP_SCALE: scaled_reg <= SCW'(shifted_c);
            ppid_pkg::OP_OUT:   m_drive_reg <= ppid_pkg::DRIVE_W'(drive_c);
            ppid_pkg::OP_PLOAD: begin
                kmag_reg <= kmag_pre_c;
                // magnitude is zero-extended, the most negative preset included
                dvd_reg  <= DW'($unsigned(pv_reg[ppid_pkg::PRESET_W-1] ? pv_neg_c : pv_reg))
                            << (2 * F);
                rem_reg  <= '0;
            end
            ppid_pkg::OP_DIV: begin
                rem_reg <= qbit_c ? ppid_pkg::KMAG_W'(trial_c - {1'b0, kmag_reg})
                                  : ppid_pkg::KMAG_W'(trial_c);
                dvd_reg <= {dvd_reg[DW-2:0], qbit_c};
            end
            default: ;
        endcase
    end

    assign stat.out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid      = m_tvalid_reg;
    assign m_drive       = m_drive_reg;

`ifndef NO_ASSERTIONS
    a_integ_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        integ_reg <= INT_HIGH)
        else $error("integral above its upper cap");

    a_drive_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> ($signed(m_drive_reg) <= ppid_pkg::DRIVE_W'(ppid_pkg::DRIVE_HIGH)
                      && $signed(m_drive_reg) >= ppid_pkg::DRIVE_W'(ppid_pkg::DRIVE_LOW)))
        else $error("drive outside clamp window");

    a_div_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == ppid_pkg::OP_DIV) |-> (rem_reg < kmag_reg))
        else $error("divider remainder not below divisor");

    a_ki_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == ppid_pkg::OP_PLOAD) |=> (forced_reg || gain_i_reg != '0))
        else $error("preset left a zero integral gain");
`endif

endmodule

[hw/rtl/positional_pid_with_integral_preset_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_pid_with_integral_preset_top
// Positional pid controller with saturating integral, integral preset and a
// clamped drive output.
// ----------------------------------------------------------------------------
// usage:
//   configuration: cfg_we / cfg_index / cfg_wdata write target (0), gain_p (1),
//   gain_i (2) and gain_d (3); write only while the block is idle.
//   input beat: s_tuser selects a control step (0) or an integral preset (1);
//   s_tdata carries measured and preset_value. one item is worked at a time.
//   a control step runs the error, the proportional and derivative products,
//   the shift-add multiplier for the integral term, saturation, sum, scaling
//   and output in turn; it yields one output beat with the clamped drive.
//   a preset is worked by the restoring divider that retires one quotient bit
//   per cycle; it yields no output beat.
//   s_tready is high whenever the sequencer is idle, also while a result waits
//   in the output register; a stalled receiver holds the next step at its last
//   cycle until the output register frees.
//   reset clears gains, setpoint, previous error, integral and the forced-ki
//   flag, and drops m_tvalid.
// ----------------------------------------------------------------------------
module positional_pid_with_integral_preset_top #(
    parameter int FRACTION_BITS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [15:0] measured, [39:16] preset_value
    input  logic        s_tuser,   // [0] action
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [15:0] drive
);

    ppid_pkg::dp_cmd_t  cmd;
    ppid_pkg::dp_stat_t stat;

    ppid_ctrl #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .item_preset(s_tuser),
        .cmd        (cmd),
        .stat       (stat)
    );

    ppid_dp #(
        .FRACTION_BITS(FRACTION_BITS)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .in_measured(s_tdata[15:0]),
        .in_preset  (s_tdata[39:16]),
        .cmd        (cmd),
        .stat       (stat),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_drive    (m_tdata)
    );

endmodule

[verif/tb_positional_pid_with_integral_preset_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_positional_pid_with_integral_preset_top
// Self-checking bench for the positional pid controller. A short table walks
// register extremes, integral presets (zero ki forcing, low integral limit)
// and output clamping, then randomized phases of control steps and presets
// run under bursty input and a stalling receiver. Every drive beat is
// compared in order with the table's known drive or a bit-accurate fixed-point model.
// ----------------------------------------------------------------------------
module tb_positional_pid_with_integral_preset_top;
    import ppid_pkg::*;

    localparam int     FB          = 8;
    localparam longint ONE         = longint'(1) << FB;
    localparam longint INTEG_MAX   = longint'(INT_HIGH_WHOLE) * ONE;
    localparam longint INTEG_MIN   = -(longint'(1) << (INT_LOW_LOG2 + FB));
    localparam longint TERM_CAP    = longint'(1) << TERM_LIMIT_LOG2;
    localparam logic [15:0] D_CEIL  = 16'(DRIVE_HIGH);
    localparam logic [15:0] D_FLOOR = 16'(DRIVE_LOW);
    localparam int QUIET_CYCLES    = 64;
    localparam int HOLD_CYCLES     = 400;
    localparam int STALL_LIMIT     = 4000;
    localparam int PHASES          = 10;
    localparam int PHASE_ITEMS     = 113;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_index = CFG_TARGET;
    logic [15:0] cfg_wdata = 16'h0000;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata   = 40'h0;   // [15:0] measured, [39:16] preset_value
    logic        s_tuser   = ACT_STEP; // [0] action
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;              // [15:0] drive

    positional_pid_with_integral_preset_top #(
        .FRACTION_BITS(FB)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // controller state as the testbench sees it
    logic signed [15:0] sp_target = '0;
    logic signed [15:0] kp = '0;
    logic signed [15:0] ki_reg = '0;
    logic signed [15:0] kd = '0;
    logic signed [16:0] last_err = '0;
    longint             integ = 0;
    bit                 ki_one = 1'b0;

    logic [15:0] pending_drives [$];
    int          fail_count = 0;
    int          idle_cycles = 0;
    int          burst_left = 0;
    bit          items_since_settle = 1'b0;
    bit          hold_armed = 1'b0;
    bit          hold_done = 1'b0;
    logic [15:0] want_drive;

    function automatic longint ki_now();
        return ki_one ? ONE : longint'(ki_reg);
    endfunction

    // returns 1 when the item yields a drive beat
    function automatic bit predict_drive(input logic act, input logic signed [15:0] meas,
                                         input logic signed [23:0] pv,
                                         output logic [15:0] drive);
        longint e, de, pd, k, kabs, iabs, prod, tot, d, mag, q, p;
        drive = '0;
        if (act == ACT_PRESET) begin
            p = longint'(pv);
            if (ki_now() == 0)
                ki_one = 1'b1;
            k = ki_now();
            kabs = (k < 0) ? -k : k;
            mag = ((p < 0) ? -p : p) * ONE * ONE;
            q = mag / kabs;
            if (q > -INTEG_MIN)
                q = -INTEG_MIN;
            integ = -q;
            return 1'b0;
        end
        e = longint'(sp_target) - longint'(meas);
        de = e - longint'(last_err);
        integ = integ + e * ONE;
        if (integ > INTEG_MAX)
            integ = INTEG_MAX;
        if (integ < INTEG_MIN)
            integ = INTEG_MIN;
        pd = (longint'(kp) * e + longint'(kd) * de) * ONE;
        k = ki_now();
        kabs = (k < 0) ? -k : k;
        iabs = (integ < 0) ? -integ : integ;
        prod = kabs * iabs;
        if (prod > TERM_CAP)
            prod = TERM_CAP;
        tot = pd + (((k < 0) != (integ < 0)) ? -prod : prod);
        // signed division truncates toward zero
        d = tot / (ONE * ONE);
        last_err = e[16:0];
        if (d > DRIVE_HIGH)
            d = DRIVE_HIGH;
        if (d < DRIVE_LOW)
            d = DRIVE_LOW;
        drive = d[15:0];
        return 1'b1;
    endfunction

    task automatic put_reg(input logic [1:0] idx, input logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        case (idx)
            CFG_TARGET: sp_target = val;
            CFG_GAIN_P: kp = val;
            CFG_GAIN_I: begin
                ki_reg = val;
                ki_one = 1'b0;
            end
            CFG_GAIN_D: kd = val;
            default: ;
        endcase
    endtask

    // lets all results drain and a trailing preset finish before a register write
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_drives.size() != 0)
            @(posedge aclk);
        repeat (QUIET_CYCLES) @(posedge aclk);
        items_since_settle = 1'b0;
    endtask

    task automatic send_item(input logic act, input logic [15:0] meas, input logic [23:0] pv,
                             input bit known, input logic [15:0] known_drive);
        logic [15:0] d;
        cfg_we   <= 1'b0;
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {pv, meas};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        items_since_settle = 1'b1;
        if (predict_drive(act, meas, pv, d))
            pending_drives.push_back(known ? known_drive : d);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 50)) @(posedge aclk);
            burst_left = $urandom_range(0, 15);
        end
    endtask

    function automatic logic [15:0] pick_gain();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'($urandom);
            default: return 16'(int'($urandom_range(0, 1536)) - 768);
        endcase
    endfunction

    typedef enum logic [1:0] {
        ROW_REG,
        ROW_ITEM,
        ROW_KNOWN
    } row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        logic [1:0]  idx;
        logic [15:0] val;
        logic        act;
        logic [15:0] meas;
        logic [23:0] pv;
        logic [15:0] drv;
    } plan_row_t;

    plan_row_t plan [34] = '{
        // gains zero after reset: drive pinned at the upper clamp
        '{ROW_KNOWN, CFG_TARGET, 16'h0000, ACT_STEP,   16'h0000, 24'h000000, D_CEIL},
        '{ROW_KNOWN, CFG_TARGET, 16'h0000, ACT_STEP,   16'h7fff, 24'h7fffff, D_CEIL},
        '{ROW_KNOWN, CFG_TARGET, 16'h0000, ACT_STEP,   16'h8000, 24'h800000, D_CEIL},
        // preset with ki zero forces ki to one
        '{ROW_ITEM,  CFG_TARGET, 16'h0000, ACT_PRESET, 16'hffff, 24'h800000, 16'h0000},
        '{ROW_KNOWN, CFG_TARGET, 16'h0000, ACT_STEP,   16'h0000, 24'h000000, D_FLOOR},
        // ki of one lsb: preset lands on the low integral limit, step saturates there
        '{ROW_REG,   CFG_GAIN_I, 16'h0001, ACT_STEP,   16'h0000, 24'h000000, 16'h0000},
        '{ROW_ITEM,  CFG_TARGET, 16'h0000, ACT_PRESET, 16'h0000, 24'h800000, 16'h0000},
        '{ROW_KNOWN, CFG_TARGET, 16'h0000, ACT_STEP,   16'h7fff, 24'hffffff, D_FLOOR},
        '{ROW_ITEM,  CFG_TARGET, 16'h0000, ACT_PRESET, 16'h1234, 24'h000000, 16'h0000},
        '{ROW_REG,   CFG_TARGET, 16'h7fff, ACT_STEP,   16'h0000, 24'h000000, 16'h0000},
        '{ROW_REG,   CFG_GAIN_P, 16'h7fff, ACT_STEP,   16'h0000, 24'h000000, 16'h0000},
        '{ROW_REG,   CFG_GAIN_I, 16'h7fff, ACT_STEP,   16'h0000, 24'h000000, 16'h0000},
        '{ROW_REG,   CFG_GAIN_D, 16'h7fff, ACT_STEP,   16'h0000, 24'h000000, 16'h0000},
        // largest error, integral hits its upper cap
        '{ROW_KNOWN, CFG_TARGET, 16'h0000, ACT_STEP,   16'h8000, 24'h555555, D_CEIL},
        '{ROW_KNOWN, CFG_TARGET, 16'h0000, ACT_STEP,   16'h7fff, 24'haaaaaa, D_FLOOR},
        '{ROW_REG,   CFG_TARGET, 16'h8000, ACT_STEP,   16'h0000, 24'h000000, 16'h0000},
        '{ROW_REG,   CFG_GAIN_P, 16'h8000, ACT_STEP,   16'h0000, 24'h000000, 16'h0000},
        '{ROW_REG,   CFG_GAIN_I, 16'h8000, ACT_STEP,   16'h0000, 24'h000000, 16'h0000},
        '{ROW_REG,   CFG_GAIN_D, 16'h8000, ACT_STEP,   16'h0000, 24'h000000, 16'h0000},
        '{ROW_KNOWN, CFG_TARGET, 16'h0000, ACT_STEP,   16'h7fff, 24'h000000, D_CEIL},
        '{ROW_ITEM,  CFG_TARGET, 16'h0000, ACT_PRESET, 16'h0000, 24'hffffff, 16'h0000},
        '{ROW_KNOWN, CFG_TARGET, 16'h0000, ACT_STEP,   16'h8000, 24'h000000, D_FLOOR},
        // mid-range gains, drive inside the clamp window
        '{ROW_REG,   CFG_TARGET, 16'd1000, ACT_STEP,   16'h0000, 24'h000000, 16'h0000},
        '{ROW_REG,   CFG_GAIN_P, 16'h0100, ACT_STEP,   16'h0000, 24'h000000, 16'h0000},
        '{ROW_REG,   CFG_GAIN_I, 16'h0000, ACT_STEP,   16'h0000, 24'h000000, 16'h0000},
        '{ROW_REG,   CFG_GAIN_D, 16'h0040, ACT_STEP,   16'h0000, 24'h000000, 16'h0000},
        '{ROW_ITEM,  CFG_TARGET, 16'h0000, ACT_STEP,   16'd3000, 24'h000000, 16'h0000},
        '{ROW_ITEM,  CFG_TARGET, 16'h0000, ACT_STEP,   16'd1500, 24'h000000, 16'h0000},
        '{ROW_ITEM,  CFG_TARGET, 16'h0000, ACT_PRESET, 16'h0000, 24'h001000, 16'h0000},
        '{ROW_ITEM,  CFG_TARGET, 16'h0000, ACT_STEP,   16'd2500, 24'h000000, 16'h0000},
        // rewriting ki drops the forced one
        '{ROW_REG,   CFG_GAIN_I, 16'hff00, ACT_STEP,   16'h0000, 24'h000000, 16'h0000},
        '{ROW_ITEM,  CFG_TARGET, 16'h0000, ACT_PRESET, 16'h0000, 24'hfffed4, 16'h0000},
        '{ROW_ITEM,  CFG_TARGET, 16'h0000, ACT_STEP,   16'd1200, 24'h000000, 16'h0000},
        '{ROW_ITEM,  CFG_TARGET, 16'h0000, ACT_STEP,   16'hec78, 24'h000000, 16'h0000}
    };

    initial begin
        int          ph, n, r, off;
        logic        act;
        logic [15:0] meas;
        logic [23:0] pv;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_REG) begin
                if (items_since_settle)
                    settle();
                put_reg(plan[i].idx, plan[i].val);
            end else begin
                send_item(plan[i].act, plan[i].meas, plan[i].pv,
                          plan[i].kind == ROW_KNOWN, plan[i].drv);
            end
        end

        for (ph = 0; ph < PHASES; ph++) begin
            settle();
            put_reg(CFG_TARGET, ($urandom_range(0, 2) == 0) ? 16'($urandom)
                                : 16'(int'($urandom_range(0, 20000)) - 10000));
            put_reg(CFG_GAIN_P, pick_gain());
            put_reg(CFG_GAIN_I, (ph % 3 == 1) ? 16'h0000 : pick_gain());
            put_reg(CFG_GAIN_D, pick_gain());
            if (ph == 2)
                hold_armed = 1'b1;
            for (n = 0; n < PHASE_ITEMS; n++) begin
                act  = ACT_STEP;
                meas = 16'($urandom);
                pv   = 24'($urandom);
                r = $urandom_range(0, 99);
                if (r < 12) begin
                    act = ACT_PRESET;
                    case ($urandom_range(0, 3))
                        0: pv = 24'(int'($urandom_range(0, 10000)) - 5000);
                        1: pv = ($urandom_range(0, 1) != 0) ? 24'h800000 : 24'h7fffff;
                        default: ;
                    endcase
                end else if (r < 72) begin
                    off  = int'($urandom_range(0, 40000)) - 20000;
                    meas = 16'(int'(sp_target) - off);
                end else if (r < 85) begin
                    meas = 16'(int'(sp_target) - int'($urandom_range(0, 100)) + 50);
                end
                send_item(act, meas, pv, 1'b0, 16'h0000);
            end
        end

        s_tvalid <= 1'b0;
        while (pending_drives.size() != 0)
            @(posedge aclk);
        repeat (QUIET_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // receiver: segments of differing stall density, plus one long hold-off
    initial begin
        int seg, mode;
        @(posedge aclk);
        while (!aresetn)
            @(posedge aclk);
        forever begin
            if (hold_armed && !hold_done) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_done = 1'b1;
            end
            seg  = $urandom_range(20, 300);
            mode = $urandom_range(0, 3);
            while (seg > 0 && !(hold_armed && !hold_done)) begin
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= 1'($urandom_range(0, 1));
                    2: m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= ($urandom_range(0, 7) != 0);
                endcase
                @(posedge aclk);
                seg--;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_drives.size() == 0) begin
                fail_count++;
                $display("%0t: drive beat with nothing expected, expected none actual %0d",
                         $time, $signed(m_tdata));
            end else begin
                want_drive = pending_drives.pop_front();
                if (m_tdata !== want_drive) begin
                    fail_count++;
                    $display("%0t: drive mismatch, expected %0d actual %0d",
                             $time, $signed(want_drive), $signed(m_tdata));
                end
            end
        end
    end

    // ends a run in which no beat moves on either side for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

endmodule
